// File: design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the rgb to hsv converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned HUE_W     = 15;
    localparam int unsigned SAT_W     = 13;
    // 3840 * 255 and 4096 * 255 both fit in 20 bits
    localparam int unsigned NUM_W     = 20;
    // one quotient bit per cell, quotients stay at or below 4096
    localparam int unsigned NUM_CELLS = 13;
    localparam int unsigned QUO_W     = NUM_CELLS;

    localparam int unsigned HUE_SIXTY     = 3840;
    localparam int unsigned HUE_GREEN_OFS = 7680;
    localparam int unsigned HUE_BLUE_OFS  = 15360;
    localparam int unsigned HUE_FULL      = 23040;
    localparam int unsigned SAT_ONE       = 4096;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] value;
    } hsv_t;

    // work carried along the divider row: two restoring divisions side by side
    typedef struct packed {
        logic [NUM_W-1:0]  rem_h;
        logic [CHAN_W-1:0] den_h;
        logic [QUO_W-1:0]  quo_h;
        logic [NUM_W-1:0]  rem_s;
        logic [CHAN_W-1:0] den_s;
        logic [QUO_W-1:0]  quo_s;
        logic              neg;
        sector_t           sector;
    } cell_t;

endpackage

// File: design/rhc_stream_if.sv
// ----------------------------------------------------------------------------
// rhc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rhc_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// File: design/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Finds max, min and hue sector, and sets up both division numerators.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic          clk,
    input  logic          rst_n,
    rhc_stream_if.sink    pixel,
    rhc_stream_if.source  dn
);

    logic                       valid_reg;
    rhc_pkg::cell_t             data_reg;
    rhc_pkg::cell_t             data_next;

    logic [rhc_pkg::CHAN_W-1:0] r;
    logic [rhc_pkg::CHAN_W-1:0] g;
    logic [rhc_pkg::CHAN_W-1:0] b;
    logic [rhc_pkg::CHAN_W-1:0] maxc;
    logic [rhc_pkg::CHAN_W-1:0] minc;
    logic [rhc_pkg::CHAN_W-1:0] delta;
    logic [rhc_pkg::CHAN_W:0]   diff;
    logic [rhc_pkg::CHAN_W-1:0] mag;
    rhc_pkg::sector_t           sector;

    assign pixel.ready = !valid_reg || dn.ready;
    assign dn.valid    = valid_reg;
    assign dn.data     = data_reg;

    always_comb
    begin
        r = pixel.data.red;
        g = pixel.data.green;
        b = pixel.data.blue;

        // ties go to red, then green
        if (r >= g && r >= b)
        begin
            sector = rhc_pkg::SEC_RED;
            maxc   = r;
            diff   = {1'b0, g} - {1'b0, b};
        end
        else if (g >= b)
        begin
            sector = rhc_pkg::SEC_GREEN;
            maxc   = g;
            diff   = {1'b0, b} - {1'b0, r};
        end
        else
        begin
            sector = rhc_pkg::SEC_BLUE;
            maxc   = b;
            diff   = {1'b0, r} - {1'b0, g};
        end

        minc = r;
        if (g < minc)
        begin
            minc = g;
        end
        if (b < minc)
        begin
            minc = b;
        end
        delta = maxc - minc;

        // divide the magnitude so the quotient truncates toward zero
        mag = diff[rhc_pkg::CHAN_W] ? rhc_pkg::CHAN_W'(-diff) : diff[rhc_pkg::CHAN_W-1:0];

        data_next.rem_h  = rhc_pkg::NUM_W'(mag) * rhc_pkg::NUM_W'(rhc_pkg::HUE_SIXTY);
        data_next.den_h  = delta;
        data_next.quo_h  = '0;
        data_next.rem_s  = rhc_pkg::NUM_W'(delta) * rhc_pkg::NUM_W'(rhc_pkg::SAT_ONE);
        data_next.den_s  = maxc;
        data_next.quo_s  = '0;
        data_next.neg    = diff[rhc_pkg::CHAN_W];
        data_next.sector = sector;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.ready && pixel.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rhc_div_cell.sv
// ----------------------------------------------------------------------------
// rhc_div_cell
// One restoring-division step for both hue and saturation quotients.
// ----------------------------------------------------------------------------
module rhc_div_cell #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    rhc_stream_if.sink    up,
    rhc_stream_if.source  dn
);

    logic                      valid_reg;
    rhc_pkg::cell_t            data_reg;
    rhc_pkg::cell_t            data_next;
    logic [rhc_pkg::NUM_W-1:0] dsh_h;
    logic [rhc_pkg::NUM_W-1:0] dsh_s;

    assign up.ready = !valid_reg || dn.ready;
    assign dn.valid = valid_reg;
    assign dn.data  = data_reg;

    always_comb
    begin
        data_next = up.data;
        dsh_h     = rhc_pkg::NUM_W'(up.data.den_h) << BIT_POS;
        dsh_s     = rhc_pkg::NUM_W'(up.data.den_s) << BIT_POS;

        if (up.data.rem_h >= dsh_h)
        begin
            data_next.rem_h          = up.data.rem_h - dsh_h;
            data_next.quo_h[BIT_POS] = 1'b1;
        end
        if (up.data.rem_s >= dsh_s)
        begin
            data_next.rem_s          = up.data.rem_s - dsh_s;
            data_next.quo_s[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Applies sign and sector offset to hue, clears grey and black cases.
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic          clk,
    input  logic          rst_n,
    rhc_stream_if.sink    up,
    rhc_stream_if.source  hsv
);

    logic                      valid_reg;
    rhc_pkg::hsv_t             data_reg;
    rhc_pkg::hsv_t             data_next;
    logic [rhc_pkg::HUE_W-1:0] base;
    logic [rhc_pkg::HUE_W-1:0] quo;

    assign up.ready  = !valid_reg || hsv.ready;
    assign hsv.valid = valid_reg;
    assign hsv.data  = data_reg;

    always_comb
    begin
        quo = rhc_pkg::HUE_W'(up.data.quo_h);
        case (up.data.sector)
            rhc_pkg::SEC_RED:
            begin
                // negative red hue wraps around the full circle
                base = up.data.neg ? rhc_pkg::HUE_W'(rhc_pkg::HUE_FULL) : '0;
            end
            rhc_pkg::SEC_GREEN:
            begin
                base = rhc_pkg::HUE_W'(rhc_pkg::HUE_GREEN_OFS);
            end
            rhc_pkg::SEC_BLUE:
            begin
                base = rhc_pkg::HUE_W'(rhc_pkg::HUE_BLUE_OFS);
            end
            default:
            begin
                base = '0;
            end
        endcase

        if (up.data.den_h == '0)
        begin
            data_next.hue = '0;
        end
        else if (up.data.neg)
        begin
            data_next.hue = base - quo;
        end
        else
        begin
            data_next.hue = base + quo;
        end

        data_next.saturation = (up.data.den_s == '0) ? '0 : rhc_pkg::SAT_W'(up.data.quo_s);
        data_next.value      = up.data.den_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rgb_to_hsv_convert_core.sv
// stages: one setup stage, 13 divider cells, one output stage, in that order
// throughput: one pixel per cycle unless hsv.ready stalls the row; each
// divider cell resolves one quotient bit of hue and saturation at once,
// so the row of 13 cells sets the depth
// reset: rst_n clears every stage valid bit, the pipeline comes up empty
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_core
// Pixel rgb to hsv conversion built as a row of restoring-division cells.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_core (
    input  logic          clk,
    input  logic          rst_n,
    rhc_stream_if.sink    pixel,
    rhc_stream_if.source  hsv
);

    rhc_stream_if #(.payload_t(rhc_pkg::cell_t)) link [rhc_pkg::NUM_CELLS+1] ();

    rhc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .dn    (link[0])
    );

    // msb first: the first cell resolves the top quotient bit
    for (genvar i = 0; i < rhc_pkg::NUM_CELLS; i++)
    begin : g_cell
        rhc_div_cell #(
            .BIT_POS (rhc_pkg::NUM_CELLS - 1 - i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (link[i]),
            .dn    (link[i+1])
        );
    end

    rhc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (link[rhc_pkg::NUM_CELLS]),
        .hsv   (hsv)
    );

endmodule
